// File: hdl/fcc_pkg.sv
package fcc_pkg;

    // array size, must stay a power of two so address wrap is a plain truncation
    localparam int FLASH_BYTES = 131072;
    localparam int ADDR_W      = $clog2(FLASH_BYTES);
    localparam int PAGE_BYTES  = 128;
    localparam int PAGE_W      = $clog2(PAGE_BYTES);
    localparam int PCNT_W      = PAGE_W + 1;
    // width of word_offset*2 + byte_index before the wrap
    localparam int RSUM_W      = (ADDR_W > 18) ? ADDR_W : 18;

    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(FLASH_BYTES - 1);
    localparam logic [PCNT_W-1:0] PCNT_LAST = PCNT_W'(PAGE_BYTES);

    localparam logic [7:0] BYTE_ERASED = 8'hFF;

    // command opcodes, top byte of the command word
    localparam logic [7:0] OP_SET_PAGE  = 8'h4B;
    localparam logic [7:0] OP_ERASE     = 8'h78;
    localparam logic [7:0] OP_ERASE_OFS = 8'hA5;
    localparam logic [7:0] OP_WRITE     = 8'hB4;
    localparam logic [7:0] OP_EXECUTE   = 8'hD2;
    localparam logic [7:0] OP_STATUS    = 8'hE1;
    localparam logic [7:0] OP_READ      = 8'hF0;

    localparam logic [63:0] STAT_ERASE     = 64'h1111800800C20000;
    localparam logic [63:0] STAT_ERASE_OFS = 64'h1111800400C20000;
    localparam logic [63:0] STAT_STATUS    = 64'h1111800100C20000;
    localparam logic [63:0] STAT_READ      = 64'h11118004F0000000;

    typedef enum logic [1:0] {
        REQ_CMD    = 2'd0,
        REQ_STATUS = 2'd1,
        REQ_WRITE  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_ERASE  = 3'd1,
        MODE_WRITE  = 3'd2,
        MODE_READ   = 3'd3,
        MODE_STATUS = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        ERR_OK         = 3'd0,
        ERR_UNKNOWN    = 3'd1,
        ERR_EXEC_READ  = 3'd2,
        ERR_READ_MODE  = 3'd3,
        ERR_WRITE_MODE = 3'd4
    } err_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_PAGE,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic latch;
        logic page_step;
        logic commit;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_page;
        logic page_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: hdl/fcc_ram.sv
module fcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/fcc_ctrl.sv
module fcc_ctrl
    import fcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t dp_sts,
    output dp_cmd_t    dp_cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        dp_cmd     = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                dp_cmd.clear_step = 1'b1;
                if (dp_sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready      = 1'b1;
                dp_cmd.latch = s_valid;
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = dp_sts.need_page ? ST_PAGE : ST_DONE;
            end
            ST_PAGE: begin
                dp_cmd.page_step = 1'b1;
                if (dp_sts.page_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (dp_sts.out_free) begin
                    dp_cmd.commit = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

// File: hdl/fcc_dp.sv
module fcc_dp
    import fcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dp_cmd_t     dp_cmd,
    output dp_status_t  dp_sts,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_command_word,
    input  logic [15:0] s_word_offset,
    input  logic [16:0] s_byte_index,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [63:0] m_status_value,
    output logic [2:0]  m_error_code
);

    // latched request
    req_t        req_reg;
    logic [31:0] cmd_reg;
    logic [15:0] woff_reg;
    logic [16:0] bidx_reg;
    logic [7:0]  wdata_reg;

    // architectural state
    mode_t             mode_reg, mode_next;
    logic [63:0]       status_reg, status_next;
    logic [ADDR_W-1:0] page_ofs_reg, page_ofs_next;

    // sweep counters
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [PCNT_W-1:0] pg_cnt_reg;

    // result register
    logic        m_valid_reg;
    logic [7:0]  rdata_reg;
    logic [63:0] rstat_reg;
    err_t        err_reg;

    logic [7:0]          op;
    logic [15+PAGE_W:0]  page_bytes;
    logic [RSUM_W-1:0]   rd_sum;
    logic [PAGE_W-1:0]   pg_idx_m1;
    err_t                err_next;
    logic [7:0]          rdata_next;
    logic                pbuf_we;
    logic [7:0]          pbuf_rdata;
    logic                flash_we;
    logic [ADDR_W-1:0]   flash_waddr;
    logic [7:0]          flash_wdata;
    logic [7:0]          flash_rdata;

    assign op         = cmd_reg[31:24];
    assign page_bytes = {cmd_reg[15:0], PAGE_W'(0)};
    assign rd_sum     = RSUM_W'({woff_reg, 1'b0}) + RSUM_W'(bidx_reg);
    assign pg_idx_m1  = pg_cnt_reg[PAGE_W-1:0] - 1'b1;

    always_ff @(posedge aclk) begin
        if (dp_cmd.latch) begin
            req_reg   <= req_t'(s_req_type);
            cmd_reg   <= s_command_word;
            woff_reg  <= s_word_offset;
            bidx_reg  <= s_byte_index;
            wdata_reg <= s_write_data;
        end
    end

    // command decode and next architectural state
    always_comb begin
        mode_next     = mode_reg;
        status_next   = status_reg;
        page_ofs_next = page_ofs_reg;
        err_next      = ERR_OK;
        rdata_next    = '0;
        unique case (req_reg)
            REQ_CMD: begin
                unique case (op)
                    OP_SET_PAGE: begin
                        page_ofs_next = page_bytes[ADDR_W-1:0];
                    end
                    OP_ERASE: begin
                        mode_next   = MODE_ERASE;
                        status_next = STAT_ERASE;
                    end
                    OP_ERASE_OFS: begin
                        page_ofs_next = page_bytes[ADDR_W-1:0];
                        status_next   = STAT_ERASE_OFS;
                    end
                    OP_WRITE: begin
                        mode_next = MODE_WRITE;
                    end
                    OP_EXECUTE: begin
                        mode_next = MODE_IDLE;
                        if (mode_reg == MODE_READ) begin
                            err_next = ERR_EXEC_READ;
                        end
                    end
                    OP_STATUS: begin
                        mode_next   = MODE_STATUS;
                        status_next = STAT_STATUS;
                    end
                    OP_READ: begin
                        mode_next   = MODE_READ;
                        status_next = STAT_READ;
                    end
                    default: begin
                        err_next = ERR_UNKNOWN;
                    end
                endcase
            end
            REQ_STATUS: begin
                if (mode_reg != MODE_STATUS) begin
                    err_next = ERR_READ_MODE;
                end
            end
            REQ_WRITE: begin
                if (mode_reg != MODE_WRITE) begin
                    err_next = ERR_WRITE_MODE;
                end
            end
            REQ_READ: begin
                if (mode_reg == MODE_READ) begin
                    rdata_next = flash_rdata;
                end else begin
                    err_next = ERR_READ_MODE;
                end
            end
            default: begin
                err_next = ERR_OK;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            status_reg   <= '0;
            page_ofs_reg <= '0;
        end else if (dp_cmd.commit) begin
            mode_reg     <= mode_next;
            status_reg   <= status_next;
            page_ofs_reg <= page_ofs_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (dp_cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pg_cnt_reg <= '0;
        end else if (dp_cmd.latch) begin
            pg_cnt_reg <= '0;
        end else if (dp_cmd.page_step) begin
            pg_cnt_reg <= pg_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (dp_cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (dp_cmd.commit) begin
            rdata_reg <= rdata_next;
            rstat_reg <= status_next;
            err_reg   <= err_next;
        end
    end

    assign pbuf_we = dp_cmd.commit && (req_reg == REQ_WRITE) && (mode_reg == MODE_WRITE);

    // page buffer read runs one entry ahead of the array write
    always_comb begin
        flash_we    = 1'b0;
        flash_waddr = clr_cnt_reg;
        flash_wdata = BYTE_ERASED;
        if (dp_cmd.clear_step) begin
            flash_we = 1'b1;
        end else if (dp_cmd.page_step && (pg_cnt_reg != '0)) begin
            flash_we    = 1'b1;
            flash_waddr = page_ofs_reg + ADDR_W'(pg_idx_m1);
            flash_wdata = (mode_reg == MODE_ERASE) ? BYTE_ERASED : pbuf_rdata;
        end
    end

    fcc_ram #(
        .WIDTH (8),
        .DEPTH (PAGE_BYTES)
    ) u_pbuf (
        .aclk  (aclk),
        .we    (pbuf_we),
        .waddr (bidx_reg[PAGE_W-1:0]),
        .wdata (wdata_reg),
        .raddr (pg_cnt_reg[PAGE_W-1:0]),
        .rdata (pbuf_rdata)
    );

    fcc_ram #(
        .WIDTH (8),
        .DEPTH (FLASH_BYTES)
    ) u_flash (
        .aclk  (aclk),
        .we    (flash_we),
        .waddr (flash_waddr),
        .wdata (flash_wdata),
        .raddr (rd_sum[ADDR_W-1:0]),
        .rdata (flash_rdata)
    );

    assign dp_sts.clear_last = (clr_cnt_reg == ADDR_LAST);
    assign dp_sts.need_page  = (req_reg == REQ_CMD) && (op == OP_EXECUTE)
                               && ((mode_reg == MODE_ERASE) || (mode_reg == MODE_WRITE));
    assign dp_sts.page_last  = (pg_cnt_reg == PCNT_LAST);
    assign dp_sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_read_data    = rdata_reg;
    assign m_status_value = rstat_reg;
    assign m_error_code   = err_reg;

endmodule

// File: hdl/flash_command_controller.sv
// flash command controller: takes one request word at a time (command, status read,
// page buffer byte write or array byte read) and returns exactly one result word with
// the read byte, the current 64-bit status and an error code. after reset the block
// first sweeps the whole array to the erased value 0xff, one byte per cycle, so
// s_ready stays low until the sweep of all FLASH_BYTES (131072) bytes is done. after
// that a request that does no page work goes through accept, decode and result load,
// and the next request can be accepted the cycle after the result is loaded, while
// that result still waits on m_ready. an execute command in erase or write mode walks
// the 128-byte page through the single array write port, one byte per cycle. array
// reads come from a memory with a registered read port, which sets the decode cycle.
// the array size is a power of two, addresses wrap by truncation
module flash_command_controller
    import fcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // request words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_command_word,
    input  logic [15:0] s_word_offset,
    input  logic [16:0] s_byte_index,
    input  logic [7:0]  s_write_data,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [63:0] m_status_value,
    output logic [2:0]  m_error_code
);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_sts;

    // sequencer: clear sweep, accept, decode, page walk, result load
    fcc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .dp_sts  (dp_sts),
        .dp_cmd  (dp_cmd)
    );

    // mode/status/offset registers, page buffer, flash array and result register
    fcc_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .dp_cmd         (dp_cmd),
        .dp_sts         (dp_sts),
        .s_req_type     (s_req_type),
        .s_command_word (s_command_word),
        .s_word_offset  (s_word_offset),
        .s_byte_index   (s_byte_index),
        .s_write_data   (s_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_read_data    (m_read_data),
        .m_status_value (m_status_value),
        .m_error_code   (m_error_code)
    );

endmodule

// File: hdl/fcc_checker.sv
module fcc_checker
    import fcc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_req_type,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_read_data,
    input logic [63:0] m_status_value,
    input logic [2:0]  m_error_code
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while previous one still in work");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_data)
            && $stable(m_status_value) && $stable(m_error_code))
        else $error("result word changed while stalled");

    // a failed access returns no data byte
    a_err_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code != ERR_OK) |-> m_read_data == 8'd0)
        else $error("data byte returned with an error");

    // a non-command request accepted with a free output yields its result word
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type != REQ_CMD) && !m_valid |-> ##3 m_valid)
        else $error("result missing after non-command request");

endmodule

bind flash_command_controller fcc_checker u_fcc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_req_type     (s_req_type),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_read_data    (m_read_data),
    .m_status_value (m_status_value),
    .m_error_code   (m_error_code)
);
